[sv/cluster_energy_centroid_core_assert.svh]
// Assertion macros shared by the cluster centroid modules.
`ifndef CLUSTER_ENERGY_CENTROID_CORE_ASSERT_SVH
`define CLUSTER_ENERGY_CENTROID_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CEC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/cec_pkg.sv]
// Shared types and constants of the cluster energy centroid block.
`timescale 1ns / 1ps
package cec_pkg;

  localparam int unsigned MAX_HITS_DEF    = 1024;
  localparam int unsigned LAYER_COUNT_DEF = 64;

  localparam int unsigned E_W         = 24;
  localparam int unsigned POS_W       = 20;
  localparam int unsigned LAYER_W     = 6;
  localparam int unsigned PROD_W      = E_W + 1 + POS_W;
  localparam int unsigned SUM_E_W     = 34;
  localparam int unsigned SUM_P_W     = 54;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_Z = 8'd2;

  // Totals of one closed cluster, handed from front to back.
  typedef struct packed {
    logic [SUM_E_W-1:0]        energy;
    logic signed [SUM_P_W-1:0] wx;
    logic signed [SUM_P_W-1:0] wy;
    logic signed [SUM_P_W-1:0] wz;
    logic [LAYER_W-1:0]        span;
    logic                      ovf;
  } cec_sums_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } cec_seed_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cec_q_status_t;

endpackage

[sv/cluster_energy_centroid_core.sv]
// Top level of the cluster energy centroid block.
// Usage:
//   Hits enter on the in channel (in_valid_i / in_stall_o), one per cycle unless
//   a closing hit waits on a full closed-cluster queue. A hit with last_hit_i high
//   closes the cluster; exactly one result then leaves on the out channel
//   (out_valid_o / out_stall_i), in cluster order.
//   Seed positions are written on the cfg channel (index 0..2 for x, y, z);
//   cfg_ready_o is always high and other indexes are ignored. Write them only
//   while no cluster is in flight.
//   out_valid_o rises after the closing hit passes the product stage, the
//   accumulate and queue push, the pop into the back part, the bit-serial
//   dividers, the step out of the divide state and the output register. A
//   zero-energy cluster skips the dividers.
//   Hits are taken every cycle while in_stall_o is low; a back-to-back stream
//   of clusters is limited by the dividers, which work on one cluster at a
//   time, the two-entry queue absorbing short bursts before in_stall_o rises.
//   Reset clears accumulators, the queue, seeds and the output valid.
//   A stalled result holds on the out ports; hits keep arriving until a closing
//   hit meets a full queue.
`timescale 1ns / 1ps
module cluster_energy_centroid_core #(
  parameter int unsigned MAX_HITS    = cec_pkg::MAX_HITS_DEF,
  parameter int unsigned LAYER_COUNT = cec_pkg::LAYER_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [cec_pkg::E_W-1:0]             hit_energy_i,
  input  logic signed [cec_pkg::POS_W-1:0]    hit_x_i,
  input  logic signed [cec_pkg::POS_W-1:0]    hit_y_i,
  input  logic signed [cec_pkg::POS_W-1:0]    hit_z_i,
  input  logic [cec_pkg::LAYER_W-1:0]         hit_layer_i,
  input  logic                                last_hit_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cec_pkg::POS_W-1:0]    centroid_x_o,
  output logic signed [cec_pkg::POS_W-1:0]    centroid_y_o,
  output logic signed [cec_pkg::POS_W-1:0]    centroid_z_o,
  output logic [cec_pkg::SUM_E_W-1:0]         total_energy_o,
  output logic [cec_pkg::LAYER_W-1:0]         layer_span_o,
  output logic                                used_seed_o,
  output logic                                hit_overflow_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cec_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [cec_pkg::POS_W-1:0]           cfg_data_i
);

  cec_pkg::cec_seed_t     seed_q;
  cec_pkg::cec_sums_t     push_data;
  cec_pkg::cec_sums_t     head;
  cec_pkg::cec_q_status_t q_status;
  logic                   push;
  logic                   pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cec_pkg::CFG_SEED_X: seed_q.x <= $signed(cfg_data_i);
        cec_pkg::CFG_SEED_Y: seed_q.y <= $signed(cfg_data_i);
        cec_pkg::CFG_SEED_Z: seed_q.z <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  cec_front #(
    .MAX_HITS    (MAX_HITS),
    .LAYER_COUNT (LAYER_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hit_energy_i (hit_energy_i),
    .hit_x_i      (hit_x_i),
    .hit_y_i      (hit_y_i),
    .hit_z_i      (hit_z_i),
    .hit_layer_i  (hit_layer_i),
    .last_hit_i   (last_hit_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  cec_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  cec_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .q_status_i     (q_status),
    .pop_o          (pop),
    .seed_i         (seed_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .centroid_x_o   (centroid_x_o),
    .centroid_y_o   (centroid_y_o),
    .centroid_z_o   (centroid_z_o),
    .total_energy_o (total_energy_o),
    .layer_span_o   (layer_span_o),
    .used_seed_o    (used_seed_o),
    .hit_overflow_o (hit_overflow_o)
  );

endmodule

[sv/cec_front.sv]
// Front part: accepts hits, forms weighted products and accumulates cluster totals.
`timescale 1ns / 1ps
module cec_front #(
  parameter int unsigned MAX_HITS    = cec_pkg::MAX_HITS_DEF,
  parameter int unsigned LAYER_COUNT = cec_pkg::LAYER_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [cec_pkg::E_W-1:0]             hit_energy_i,
  input  logic signed [cec_pkg::POS_W-1:0]    hit_x_i,
  input  logic signed [cec_pkg::POS_W-1:0]    hit_y_i,
  input  logic signed [cec_pkg::POS_W-1:0]    hit_z_i,
  input  logic [cec_pkg::LAYER_W-1:0]         hit_layer_i,
  input  logic                                last_hit_i,
  input  cec_pkg::cec_q_status_t              q_status_i,
  output logic                                push_o,
  output cec_pkg::cec_sums_t                  push_data_o
);

  localparam int unsigned CNT_W = $clog2(MAX_HITS + 1);
  localparam logic [cec_pkg::LAYER_W-1:0] LAYER_MAX = cec_pkg::LAYER_W'(LAYER_COUNT - 1);

  logic                 accept;
  logic                 drain;
  logic                 take;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;

  logic                               s1_valid_q, s1_valid_d;
  logic                               s1_last_q;
  logic                               s1_acc_q;
  logic                               s1_ovf_q;
  logic                               s1_nz_q;
  logic [cec_pkg::E_W-1:0]            s1_e_q;
  logic signed [cec_pkg::PROD_W-1:0]  s1_px_q, s1_py_q, s1_pz_q;
  logic [cec_pkg::LAYER_W-1:0]        s1_layer_q;
  logic [cec_pkg::LAYER_W-1:0]        layer_sat;

  logic [cec_pkg::SUM_E_W-1:0]        esum_q, esum_d;
  logic signed [cec_pkg::SUM_P_W-1:0] wx_q, wx_d, wy_q, wy_d, wz_q, wz_d;
  logic [cec_pkg::LAYER_W-1:0]        lo_q, lo_d, hi_q, hi_d;

  // Stage one may only hold back when a closing hit meets a full queue.
  assign in_stall_o = s1_valid_q && s1_last_q && q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign drain      = s1_valid_q && !(s1_last_q && q_status_i.full);
  assign push_o     = drain && s1_last_q;
  assign take       = cnt_q < CNT_W'(MAX_HITS);
  assign layer_sat  = (hit_layer_i > LAYER_MAX) ? LAYER_MAX : hit_layer_i;

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (last_hit_i) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        cnt_d = take ? cnt_q + CNT_W'(1) : cnt_q;
        ovf_d = ovf_q || !take;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (drain) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q  <= last_hit_i;
      s1_acc_q   <= take;
      s1_ovf_q   <= ovf_q || !take;
      s1_nz_q    <= (cnt_q != '0) || take;
      s1_e_q     <= hit_energy_i;
      s1_px_q    <= $signed({1'b0, hit_energy_i}) * hit_x_i;
      s1_py_q    <= $signed({1'b0, hit_energy_i}) * hit_y_i;
      s1_pz_q    <= $signed({1'b0, hit_energy_i}) * hit_z_i;
      s1_layer_q <= layer_sat;
    end
  end

  // Totals including the hit in stage one when it is within MAX_HITS.
  always_comb begin
    esum_d = esum_q;
    wx_d   = wx_q;
    wy_d   = wy_q;
    wz_d   = wz_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    if (s1_acc_q) begin
      esum_d = esum_q + {{(cec_pkg::SUM_E_W - cec_pkg::E_W){1'b0}}, s1_e_q};
      wx_d   = wx_q + {{(cec_pkg::SUM_P_W - cec_pkg::PROD_W){s1_px_q[cec_pkg::PROD_W-1]}},
                       s1_px_q};
      wy_d   = wy_q + {{(cec_pkg::SUM_P_W - cec_pkg::PROD_W){s1_py_q[cec_pkg::PROD_W-1]}},
                       s1_py_q};
      wz_d   = wz_q + {{(cec_pkg::SUM_P_W - cec_pkg::PROD_W){s1_pz_q[cec_pkg::PROD_W-1]}},
                       s1_pz_q};
      lo_d   = (s1_layer_q < lo_q) ? s1_layer_q : lo_q;
      hi_d   = (s1_layer_q > hi_q) ? s1_layer_q : hi_q;
    end
  end

  always_comb begin
    push_data_o.energy = esum_d;
    push_data_o.wx     = wx_d;
    push_data_o.wy     = wy_d;
    push_data_o.wz     = wz_d;
    push_data_o.span   = (s1_nz_q && (hi_d >= lo_d)) ? hi_d - lo_d : '0;
    push_data_o.ovf    = s1_ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q <= '0;
      wx_q   <= '0;
      wy_q   <= '0;
      wz_q   <= '0;
      lo_q   <= LAYER_MAX;
      hi_q   <= '0;
    end else if (push_o) begin
      // Clear for the next cluster.
      esum_q <= '0;
      wx_q   <= '0;
      wy_q   <= '0;
      wz_q   <= '0;
      lo_q   <= LAYER_MAX;
      hi_q   <= '0;
    end else if (drain) begin
      esum_q <= esum_d;
      wx_q   <= wx_d;
      wy_q   <= wy_d;
      wz_q   <= wz_d;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
    end
  end

endmodule

[sv/cec_queue.sv]
// Short queue of closed-cluster totals between the front and back parts.
`timescale 1ns / 1ps
`include "cluster_energy_centroid_core_assert.svh"
module cec_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  cec_pkg::cec_sums_t      push_data_i,
  input  logic                    pop_i,
  output cec_pkg::cec_sums_t      head_o,
  output cec_pkg::cec_q_status_t  status_o
);

  localparam int unsigned DEPTH = cec_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cec_pkg::cec_sums_t mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= next_ptr(wr_q);
      end
      if (pop_i) begin
        rd_q <= next_ptr(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  assign head_o         = mem_q[rd_q];
  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);

  `CEC_ASSERT(a_push_room, push_i, cnt_q < CNT_W'(DEPTH), "push into a full queue")
  `CEC_ASSERT(a_pop_data, pop_i, cnt_q != '0, "pop from an empty queue")

endmodule

[sv/cec_div.sv]
// Restoring divider: signed weighted sum over total energy, one quotient bit a cycle.
`timescale 1ns / 1ps
module cec_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [cec_pkg::SUM_P_W-1:0]   dividend_i,
  input  logic [cec_pkg::SUM_E_W-1:0]          divisor_i,
  output logic                                 busy_o,
  output logic signed [cec_pkg::POS_W-1:0]     quot_o
);

  localparam int unsigned NW    = cec_pkg::SUM_P_W;
  localparam int unsigned DW    = cec_pkg::SUM_E_W;
  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    rem_q;
  logic [NW-1:0]    quo_q;
  logic [DW-1:0]    dvs_q;
  logic             neg_q;
  logic [DW:0]      shifted;
  logic [DW:0]      diff;
  logic             ge;
  logic [NW-1:0]    mag;
  logic [NW-1:0]    quo_neg;

  assign mag     = dividend_i[NW-1] ? NW'(-dividend_i) : NW'(dividend_i);
  assign shifted = {rem_q, quo_q[NW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign quo_neg = -quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= mag;
      dvs_q <= divisor_i;
      neg_q <= dividend_i[NW-1];
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  // Truncation toward zero: divide magnitudes, restore the sign.
  assign quot_o = neg_q ? quo_neg[cec_pkg::POS_W-1:0] : quo_q[cec_pkg::POS_W-1:0];

endmodule

[sv/cec_back.sv]
// Back part: pops cluster totals, divides or takes the seeds, shows the result.
`timescale 1ns / 1ps
`include "cluster_energy_centroid_core_assert.svh"
module cec_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cec_pkg::cec_sums_t                 head_i,
  input  cec_pkg::cec_q_status_t             q_status_i,
  output logic                               pop_o,
  input  cec_pkg::cec_seed_t                 seed_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [cec_pkg::POS_W-1:0]   centroid_x_o,
  output logic signed [cec_pkg::POS_W-1:0]   centroid_y_o,
  output logic signed [cec_pkg::POS_W-1:0]   centroid_z_o,
  output logic [cec_pkg::SUM_E_W-1:0]        total_energy_o,
  output logic [cec_pkg::LAYER_W-1:0]        layer_span_o,
  output logic                               used_seed_o,
  output logic                               hit_overflow_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]                      state_q, state_d;
  cec_pkg::cec_sums_t              item_q;
  logic                            start;
  logic                            busy_x, busy_y, busy_z;
  logic signed [cec_pkg::POS_W-1:0] qx, qy, qz;
  logic                            out_free;
  logic                            out_load;
  logic                            out_valid_q, out_valid_d;
  logic                            seeded;

  assign pop_o    = (state_q == S_IDLE) && !q_status_i.empty;
  assign start    = pop_o && (head_i.energy != '0);
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == S_HOLD) && out_free;
  assign seeded   = (item_q.energy == '0);

  cec_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i (head_i.wx),
    .divisor_i  (head_i.energy),
    .busy_o     (busy_x),
    .quot_o     (qx)
  );

  cec_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i (head_i.wy),
    .divisor_i  (head_i.energy),
    .busy_o     (busy_y),
    .quot_o     (qy)
  );

  cec_div u_div_z (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i (head_i.wz),
    .divisor_i  (head_i.energy),
    .busy_o     (busy_z),
    .quot_o     (qz)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          state_d = start ? S_DIV : S_HOLD;
        end
      end
      S_DIV: begin
        if (!(busy_x || busy_y || busy_z)) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= head_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      centroid_x_o   <= seeded ? seed_i.x : qx;
      centroid_y_o   <= seeded ? seed_i.y : qy;
      centroid_z_o   <= seeded ? seed_i.z : qz;
      total_energy_o <= item_q.energy;
      layer_span_o   <= item_q.span;
      used_seed_o    <= seeded;
      hit_overflow_o <= item_q.ovf;
    end
  end

  assign out_valid_o = out_valid_q;

  `CEC_ASSERT(a_idle_quiet, state_q == S_IDLE, !(busy_x || busy_y || busy_z), "divider busy while idle")
  `CEC_ASSERT_NEXT(a_load_shows, out_load, out_valid_o, "loaded result not shown")

endmodule
